// ----- hdl/cepi_pkg.sv -----
// Shared types, constants and functions for the chroma eighth-pel interpolator.
package cepi_pkg;

  localparam int DEF_MAX_BLOCK = 32;
  localparam int QUEUE_DEPTH   = 2;
  localparam int SUM_W         = 24;

  typedef enum logic [1:0] {
    S_IDLE,
    S_FILT,
    S_OUT
  } back_state_t;

  // one classified item between the front and the back
  typedef struct packed {
    logic signed [15:0] h;
    logic [1:0]         rm3;
    logic [2:0]         fy;
    logic               fx0;
    logic               fy0;
    logic               wr;
    logic               emit;
    logic               last;
  } work_t;

  localparam int WORK_W = $bits(work_t);

  function automatic logic signed [7:0] coef(input logic [2:0] ph, input logic [1:0] k);
    logic signed [7:0] r;
    r = 8'sd0;
    case (ph)
      3'd0: case (k) 2'd0: r = 8'sd0;  2'd1: r = 8'sd64; 2'd2: r = 8'sd0;  default: r = 8'sd0;  endcase
      3'd1: case (k) 2'd0: r = -8'sd2; 2'd1: r = 8'sd58; 2'd2: r = 8'sd10; default: r = -8'sd2; endcase
      3'd2: case (k) 2'd0: r = -8'sd4; 2'd1: r = 8'sd54; 2'd2: r = 8'sd16; default: r = -8'sd2; endcase
      3'd3: case (k) 2'd0: r = -8'sd6; 2'd1: r = 8'sd46; 2'd2: r = 8'sd28; default: r = -8'sd4; endcase
      3'd4: case (k) 2'd0: r = -8'sd4; 2'd1: r = 8'sd36; 2'd2: r = 8'sd36; default: r = -8'sd4; endcase
      3'd5: case (k) 2'd0: r = -8'sd4; 2'd1: r = 8'sd28; 2'd2: r = 8'sd46; default: r = -8'sd6; endcase
      3'd6: case (k) 2'd0: r = -8'sd2; 2'd1: r = 8'sd16; 2'd2: r = 8'sd54; default: r = -8'sd4; endcase
      default: case (k) 2'd0: r = -8'sd2; 2'd1: r = 8'sd10; 2'd2: r = 8'sd58; default: r = -8'sd2; endcase
    endcase
    return r;
  endfunction

  // residue mod 3 of an 8-bit value: even bits weigh 1, odd bits weigh 2
  function automatic logic [1:0] mod3(input logic [7:0] v);
    logic [3:0] s;
    logic [1:0] r;
    s = 4'd0;
    for (int i = 0; i < 8; i++) begin
      if (v[i]) s = s + ((i % 2 == 0) ? 4'd1 : 4'd2);
    end
    case (s)
      4'd0, 4'd3, 4'd6, 4'd9, 4'd12: r = 2'd0;
      4'd1, 4'd4, 4'd7, 4'd10:       r = 2'd1;
      default:                       r = 2'd2;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] clip8(input logic signed [SUM_W-1:0] v);
    logic [15:0] r;
    if (v < 0) r = 16'd0;
    else if (v > 255) r = 16'd255;
    else r = {8'd0, v[7:0]};
    return r;
  endfunction

  function automatic logic [15:0] sat16(input logic signed [SUM_W-1:0] v);
    logic [15:0] r;
    if (v < -32768) r = 16'h8000;
    else if (v > 32767) r = 16'h7fff;
    else r = v[15:0];
    return r;
  endfunction

endpackage

// ----- hdl/cepi_ram.sv -----
// Generic single-port-write, registered-read RAM.
module cepi_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

endmodule

// ----- hdl/cepi_front.sv -----
// Front end: window position tracking, horizontal filter and item classification.
module cepi_front import cepi_pkg::*; #(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic [7:0]                   sample,
  input  logic [2:0]                   frac_x,
  input  logic [2:0]                   frac_y,
  input  logic [5:0]                   block_width,
  input  logic [5:0]                   block_height,
  output work_t                        work,
  output logic [$clog2(MAX_BLOCK)-1:0] col_idx
);

  localparam int CW = $clog2(MAX_BLOCK + 3);
  localparam int AW = $clog2(MAX_BLOCK);

  logic [CW-1:0] col, row, col_next, row_next;
  logic [1:0]    rm3, rm3_next;
  logic [7:0]    sh0, sh1, sh2;
  logic [CW-1:0] lastc, lastr, cs, rs;
  logic [1:0]    rm3s;
  logic [6:0]    szw, szh;
  logic signed [15:0] hsum;
  logic          accept;

  assign accept = in_valid && in_ready;

  always_comb begin
    szw = {1'b0, block_width};
    szh = {1'b0, block_height};
    if (szw == 7'd0) szw = 7'd1;
    if (szw > 7'(MAX_BLOCK)) szw = 7'(MAX_BLOCK);
    if (szh == 7'd0) szh = 7'd1;
    if (szh > 7'(MAX_BLOCK)) szh = 7'(MAX_BLOCK);
    lastc = CW'(szw) + CW'(2);
    lastr = CW'(szh) + CW'(2);
    cs    = (col > lastc) ? lastc : col;
    rs    = (row > lastr) ? lastr : row;
    rm3s  = (row > lastr) ? mod3(8'(lastr)) : rm3;
  end

  always_comb begin
    hsum = 16'(coef(frac_x, 2'd0) * $signed({1'b0, sh2})
             + coef(frac_x, 2'd1) * $signed({1'b0, sh1})
             + coef(frac_x, 2'd2) * $signed({1'b0, sh0})
             + coef(frac_x, 2'd3) * $signed({1'b0, sample}));
    work.h    = (frac_x == 3'd0) ? $signed({8'd0, sh1}) : hsum;
    work.rm3  = rm3s;
    work.fy   = frac_y;
    work.fx0  = (frac_x == 3'd0);
    work.fy0  = (frac_y == 3'd0);
    work.wr   = (cs >= CW'(3));
    work.emit = (cs >= CW'(3)) && (rs >= CW'(3));
    work.last = (cs == lastc) && (rs == lastr);
    col_idx   = AW'(cs - CW'(3));
  end

  always_comb begin
    if (cs == lastc) begin
      col_next = '0;
      if (rs == lastr) begin
        row_next = '0;
        rm3_next = 2'd0;
      end else begin
        row_next = rs + CW'(1);
        rm3_next = (rm3s == 2'd2) ? 2'd0 : rm3s + 2'd1;
      end
    end else begin
      col_next = cs + CW'(1);
      row_next = rs;
      rm3_next = rm3s;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
      rm3 <= 2'd0;
      sh0 <= 8'd0;
      sh1 <= 8'd0;
      sh2 <= 8'd0;
    end else if (accept) begin
      col <= col_next;
      row <= row_next;
      rm3 <= rm3_next;
      sh0 <= sample;
      sh1 <= sh0;
      sh2 <= sh1;
    end
  end

endmodule

// ----- hdl/cepi_queue.sv -----
// Short register queue between the front and the back.
module cepi_queue import cepi_pkg::*; #(
  parameter int WIDTH = 32,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             nonempty,
  output logic [WIDTH-1:0] head
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [WIDTH-1:0] slots [DEPTH];
  logic [PW-1:0]    wptr, rptr;
  logic [PW:0]      count;

  assign full     = (count == (PW+1)'(DEPTH));
  assign nonempty = (count != '0);
  assign head     = slots[rptr];

  always_ff @(posedge clk) begin
    if (push) slots[wptr] <= push_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= '0;
      rptr  <= '0;
      count <= '0;
    end else begin
      if (push) wptr <= (wptr == PW'(DEPTH - 1)) ? '0 : wptr + PW'(1);
      if (pop)  rptr <= (rptr == PW'(DEPTH - 1)) ? '0 : rptr + PW'(1);
      count <= count + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("queue overrun");
  assert property (@(posedge clk) disable iff (rst) pop |-> nonempty)
    else $error("queue underrun");
  assert property (@(posedge clk) disable iff (rst) count <= (PW+1)'(DEPTH))
    else $error("queue count out of range");

endmodule

// ----- hdl/cepi_back.sv -----
// Back end: row store access, vertical filter, rounding and the output register.
module cepi_back import cepi_pkg::*; #(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_wdata,
  input  logic                         q_nonempty,
  input  work_t                        q_work,
  input  logic [$clog2(MAX_BLOCK)-1:0] q_col,
  output logic                         q_pop,
  output logic                         m_valid,
  input  logic                         m_ready,
  output logic [15:0]                  m_value,
  output logic                         m_last
);

  localparam int AW = $clog2(MAX_BLOCK);

  back_state_t state, state_next;
  logic        output_mode;
  work_t       w;
  logic [AW-1:0] wc;
  logic [47:0] rdata, rowd;
  logic signed [15:0] a, b, d, brg;
  logic signed [SUM_W-1:0] sum;
  logic signed [SUM_W-1:0] hx, t1, t2;
  logic [15:0] v;
  logic        go, ram_we;
  logic [47:0] wdata;

  assign q_pop = (state == S_IDLE) && q_nonempty;
  assign go    = (state == S_OUT) && (!w.emit || !m_valid || m_ready);

  cepi_ram #(.WIDTH(48), .DEPTH(MAX_BLOCK)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wc),
    .wdata (wdata),
    .re    (q_pop),
    .raddr (q_col),
    .rdata (rdata)
  );

  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:  if (q_nonempty) state_next = S_FILT;
      S_FILT:  state_next = S_OUT;
      S_OUT:   if (go) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_comb begin
    case (w.rm3)
      2'd0:    begin a = rdata[15:0];  b = rdata[31:16]; d = rdata[47:32]; end
      2'd1:    begin a = rdata[31:16]; b = rdata[47:32]; d = rdata[15:0];  end
      default: begin a = rdata[47:32]; b = rdata[15:0];  d = rdata[31:16]; end
    endcase
    wdata = rowd;
    case (w.rm3)
      2'd0:    wdata[15:0]  = w.h;
      2'd1:    wdata[31:16] = w.h;
      default: wdata[47:32] = w.h;
    endcase
    ram_we = go && w.wr;
  end

  always_comb begin
    hx = SUM_W'(w.h);
    t1 = hx + SUM_W'(32);
    t2 = sum + SUM_W'(32);
    if (w.fx0 && w.fy0) v = output_mode ? 16'({brg, 6'd0}) : brg;
    else if (w.fy0)     v = output_mode ? w.h : clip8(t1 >>> 6);
    else if (w.fx0)     v = output_mode ? sum[15:0] : clip8(t2 >>> 6);
    else                v = output_mode ? sat16(sum >>> 6)
                                        : clip8((sum + SUM_W'(2048)) >>> 12);
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      w  <= q_work;
      wc <= q_col;
    end
    if (state == S_FILT) begin
      rowd <= rdata;
      brg  <= b;
      sum  <= SUM_W'(coef(w.fy, 2'd0) * a + coef(w.fy, 2'd1) * b
                   + coef(w.fy, 2'd2) * d + coef(w.fy, 2'd3) * w.h);
    end
    if (go && w.emit) begin
      m_value <= v;
      m_last  <= w.last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      output_mode <= 1'b0;
      m_valid     <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) output_mode <= cfg_wdata;
      if (go && w.emit) m_valid <= 1'b1;
      else if (m_ready) m_valid <= 1'b0;
    end
  end

  assert property (@(posedge clk) disable iff (rst) state == S_FILT |-> $past(q_pop))
    else $error("filter step without a popped item");
  assert property (@(posedge clk) disable iff (rst)
      state == S_OUT |-> ($past(state) == S_FILT || $past(state) == S_OUT))
    else $error("output step out of sequence");
  assert property (@(posedge clk) disable iff (rst) ram_we |-> state == S_OUT && w.wr)
    else $error("row store written outside the output step");

endmodule

// ----- hdl/chroma_eighth_pel_interpolator.sv -----
// Chroma eighth-pel interpolator top level.
// Reference window samples, (W+3) by (H+3) in raster order starting one row up and one
// column left of the block, enter on s_tdata; W*H predicted samples leave on m_tdata in
// raster order, m_tlast marking the block's last one. Each item passes through the back
// end's steps in order (row store read, vertical filter, round and write back); the front
// accepts into a two-entry queue meanwhile. output_mode (cfg_wdata, written when cfg_we is high) picks
// clipped 8-bit pixels (0) or 16-bit intermediate values (1). The row store holds
// MAX_BLOCK columns of three 16-bit rows.
module chroma_eighth_pel_interpolator import cepi_pkg::*; #(
  parameter int MAX_BLOCK = DEF_MAX_BLOCK
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // sample, frac_x, frac_y, block_width, block_height
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [15:0] m_tdata,   // value
  output logic        m_tlast    // last_of_block
);

  localparam int AW = $clog2(MAX_BLOCK);

  work_t         f_work, q_work;
  logic [AW-1:0] f_col, q_col;
  logic          q_full, q_nonempty, q_pop;

  assign s_tready = !q_full;

  cepi_front #(.MAX_BLOCK(MAX_BLOCK)) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .sample       (s_tdata[7:0]),
    .frac_x       (s_tdata[10:8]),
    .frac_y       (s_tdata[13:11]),
    .block_width  (s_tdata[19:14]),
    .block_height (s_tdata[25:20]),
    .work         (f_work),
    .col_idx      (f_col)
  );

  cepi_queue #(.WIDTH(WORK_W + AW), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (s_tvalid && s_tready),
    .push_data ({f_col, f_work}),
    .full      (q_full),
    .pop       (q_pop),
    .nonempty  (q_nonempty),
    .head      ({q_col, q_work})
  );

  cepi_back #(.MAX_BLOCK(MAX_BLOCK)) u_back (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_wdata  (cfg_wdata),
    .q_nonempty (q_nonempty),
    .q_work     (q_work),
    .q_col      (q_col),
    .q_pop      (q_pop),
    .m_valid    (m_tvalid),
    .m_ready    (m_tready),
    .m_value    (m_tdata),
    .m_last     (m_tlast)
  );

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the chroma eighth-pel interpolator.
`timescale 1ns / 100ps

module tb;
  import cepi_pkg::*;

  localparam int MAXB = 32;

  typedef struct packed {
    logic [15:0] value;
    logic        last;
  } pred_t;

  typedef struct {
    logic [7:0] smp;
    logic [2:0] fx;
    logic [2:0] fy;
    logic [5:0] bw;
    logic [5:0] bh;
  } win_item_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        cfg_we = 1'b0;
  logic        cfg_wdata = 1'b0;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [31:0] s_tdata = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [15:0] m_tdata;
  logic        m_tlast;

  chroma_eighth_pel_interpolator dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast)
  );

  always #4 clk = ~clk;

  // predictor state
  logic signed [15:0] row_store [3*MAXB];
  logic [7:0]         hist [3];
  int unsigned        col_pos, row_pos;
  logic               mode_q;
  pred_t              pred_q [$];
  int                 errors = 0;
  bit                 stim_done = 0;
  logic [15:0]        last_seen = '0;

  function automatic int tap_coef(input logic [2:0] ph, input int k);
    int t [8][4] = '{'{0, 64, 0, 0}, '{-2, 58, 10, -2}, '{-4, 54, 16, -2},
                     '{-6, 46, 28, -4}, '{-4, 36, 36, -4}, '{-4, 28, 46, -6},
                     '{-2, 16, 54, -4}, '{-2, 10, 58, -2}};
    return t[ph][k];
  endfunction

  function automatic int filt4(input logic [2:0] ph, input int a, b, c, d);
    return tap_coef(ph, 0) * a + tap_coef(ph, 1) * b + tap_coef(ph, 2) * c
           + tap_coef(ph, 3) * d;
  endfunction

  function automatic int clamp_px(input int v);
    return v < 0 ? 0 : (v > 255 ? 255 : v);
  endfunction

  function automatic int clamp_s16(input int v);
    return v < -32768 ? -32768 : (v > 32767 ? 32767 : v);
  endfunction

  function automatic int unsigned eff_size(input logic [5:0] f);
    return f == 0 ? 1 : (f > MAXB ? MAXB : f);
  endfunction

  task automatic predict_item(input win_item_t it);
    int unsigned lastc, lastr, c;
    int h, a, b, d, v, sum;
    pred_t p;
    lastc = eff_size(it.bw) + 2;
    lastr = eff_size(it.bh) + 2;
    if (col_pos > lastc) col_pos = lastc;
    if (row_pos > lastr) row_pos = lastr;
    if (col_pos >= 3) begin
      c = col_pos - 3;
      h = it.fx != 0 ? filt4(it.fx, hist[2], hist[1], hist[0], it.smp) : int'(hist[1]);
      a = row_store[(row_pos % 3) * MAXB + c];
      b = row_store[((row_pos + 1) % 3) * MAXB + c];
      d = row_store[((row_pos + 2) % 3) * MAXB + c];
      if (row_pos >= 3) begin
        if (it.fx == 0 && it.fy == 0) v = mode_q ? b * 64 : b;
        else if (it.fy == 0) v = mode_q ? h : clamp_px((h + 32) >>> 6);
        else begin
          sum = filt4(it.fy, a, b, d, h);
          if (it.fx == 0) v = mode_q ? sum : clamp_px((sum + 32) >>> 6);
          else v = mode_q ? clamp_s16(sum >>> 6) : clamp_px((sum + 2048) >>> 12);
        end
        p.value = v[15:0];
        p.last  = (col_pos == lastc && row_pos == lastr);
        pred_q.push_back(p);
      end
      row_store[(row_pos % 3) * MAXB + c] = h[15:0];
    end
    hist[2] = hist[1];
    hist[1] = hist[0];
    hist[0] = it.smp;
    if (col_pos == lastc) begin
      col_pos = 0;
      row_pos = (row_pos == lastr) ? 0 : row_pos + 1;
    end else col_pos++;
  endtask

  function automatic int gap_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(4, 30);
  endfunction

  bit bursty = 0;

  // called at a falling edge; leaves tvalid high after the item so a following
  // item can go back to back, wait_drain and set_mode drop it
  task automatic send_item(input win_item_t it);
    int g;
    g = bursty ? 0 : gap_len();
    if (g > 0) begin
      s_tvalid <= 1'b0;
      repeat (g) @(negedge clk);
    end
    s_tdata  <= {6'd0, it.bh, it.bw, it.fy, it.fx, it.smp};
    s_tvalid <= 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predict_item(it);
    @(negedge clk);
  endtask

  // a whole window; content by pattern (random, all 0, all 255 or alternating), one size and phase
  task automatic send_block(input int w, input int h, input logic [2:0] fx,
                            input logic [2:0] fy, input int pattern);
    win_item_t it;
    for (int i = 0; i < (w + 3) * (h + 3); i++) begin
      it.fx = fx;
      it.fy = fy;
      it.bw = w[5:0];
      it.bh = h[5:0];
      case (pattern)
        0: it.smp = 8'($urandom);
        1: it.smp = 8'd0;
        2: it.smp = 8'd255;
        default: it.smp = (i % 2) ? 8'd255 : 8'd0;
      endcase
      send_item(it);
    end
  endtask

  task automatic wait_drain();
    s_tvalid <= 1'b0;
    while (pred_q.size() != 0) @(negedge clk);
    repeat (12) @(negedge clk);
  endtask

  task automatic set_mode(input logic m);
    s_tvalid  <= 1'b0;
    cfg_wdata <= m;
    cfg_we    <= 1'b1;
    @(negedge clk);
    cfg_we    <= 1'b0;
    mode_q = m;
  endtask

  // directed rows: w, h, fx, fy, pattern, expected last value (-1: predictor only)
  typedef struct {
    int w, h, fx, fy, pat, first_val;
  } dir_row_t;

  dir_row_t dir_tab [] = '{
    '{1, 1, 0, 0, 1, 0},
    '{1, 1, 0, 0, 2, 255},
    '{1, 1, 4, 4, 2, 255},
    '{1, 1, 4, 4, 1, 0},
    '{2, 2, 1, 0, 0, -1},
    '{2, 2, 0, 7, 0, -1},
    '{2, 1, 3, 5, 3, -1},
    '{1, 2, 7, 2, 3, -1},
    '{32, 1, 6, 1, 0, -1},
    '{1, 32, 2, 6, 0, -1}
  };

  // output side: ready low for random gaps, sampled at rising edge
  initial begin
    int g;
    forever begin
      @(negedge clk);
      g = (stim_done || bursty) ? 0 : gap_len();
      if (g == 0) m_tready <= 1'b1;
      else begin
        m_tready <= 1'b0;
        repeat (g - 1) @(negedge clk);
      end
    end
  end

  always @(posedge clk) begin
    pred_t e;
    if (!rst && m_tvalid && m_tready) begin
      last_seen = m_tdata;
      if (pred_q.size() == 0) begin
        $display("%0t unexpected item: actual value %h last %b", $time, m_tdata, m_tlast);
        errors++;
      end else begin
        e = pred_q.pop_front();
        if (m_tdata !== e.value)
          begin
            $display("%0t value: expected %h actual %h", $time, e.value, m_tdata);
            errors++;
          end
        if (m_tlast !== e.last) begin
          $display("%0t last: expected %b actual %b", $time, e.last, m_tlast);
          errors++;
        end
      end
    end
  end

  initial begin
    int w, h, r;
    for (int i = 0; i < 3 * MAXB; i++) row_store[i] = '0;
    hist = '{default: 8'd0};
    col_pos = 0;
    row_pos = 0;
    mode_q = 1'b0;
    repeat (4) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (dir_tab[k]) begin
      if (k == 6) begin
        wait_drain();
        set_mode(1'b1);
      end
      send_block(dir_tab[k].w, dir_tab[k].h, 3'(dir_tab[k].fx), 3'(dir_tab[k].fy),
                 dir_tab[k].pat);
      if (dir_tab[k].first_val >= 0) begin
        wait_drain();
        if (last_seen !== 16'(dir_tab[k].first_val)) begin
          $display("%0t directed value: expected %h actual %h", $time,
                   16'(dir_tab[k].first_val), last_seen);
          errors++;
        end
      end
    end
    wait_drain();

    // random blocks across both modes
    for (int phase = 0; phase < 4; phase++) begin
      set_mode(phase[0]);
      bursty = (phase == 2);
      for (int n = 0; n < 3; n++) begin
        r = $urandom_range(0, 9);
        w = (r == 0) ? $urandom_range(9, 32) : $urandom_range(1, 4);
        h = (r == 1) ? $urandom_range(9, 32) : $urandom_range(1, 4);
        send_block(w, h, 3'($urandom), 3'($urandom), ($urandom_range(0, 9) < 8) ? 0 : 3);
      end
      wait_drain();
    end

    // noise: odd sizes (0 and above the maximum) and mid-block changes
    set_mode(1'b0);
    begin
      win_item_t it;
      for (int i = 0; i < 100; i++) begin
        it.smp = 8'($urandom);
        it.fx  = 3'($urandom);
        it.fy  = 3'($urandom);
        it.bw  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd2;
        it.bh  = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd2;
        send_item(it);
      end
    end
    stim_done = 1;
    wait_drain();
    repeat (20) @(negedge clk);
    if (errors == 0) $display("SCOREBOARD CLEAN");
    else $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    #20ms;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
